>>> design/lfo_pkg.sv
// Shared types and constants for the LED fade / auto-off controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lfo_pkg;

  localparam int unsigned LevelW  = 7;
  localparam int unsigned OffW    = 16;
  localparam int unsigned TicksW  = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned InDatW  = 8;
  localparam int unsigned OutDatW = 16;

  localparam logic [LevelW-1:0] MinLevelRst  = 7'd10;
  localparam logic [LevelW-1:0] MaxLevelRst  = 7'd100;
  localparam logic [OffW-1:0]   OffDelayRst  = 16'd1500;
  localparam logic [TicksW-1:0] PollTicksRst = 10'd50;
  localparam logic [LevelW-1:0] StepSizeRst  = 7'd2;
  localparam logic [TicksW-1:0] StepTicksRst = 10'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_LEVEL  = 3'd0,
    CFG_MAX_LEVEL  = 3'd1,
    CFG_OFF_DELAY  = 3'd2,
    CFG_POLL_TICKS = 3'd3,
    CFG_STEP_SIZE  = 3'd4,
    CFG_STEP_TICKS = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FADE_STEADY = 2'd0,
    FADE_UP     = 2'd1,
    FADE_DOWN   = 2'd2
  } fade_mode_e;

  typedef struct packed {
    logic [LevelW-1:0] min_level;
    logic [LevelW-1:0] max_level;
    logic [OffW-1:0]   off_delay_ticks;
    logic [TicksW-1:0] poll_ticks;
    logic [LevelW-1:0] step_size;
    logic [TicksW-1:0] step_ticks;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              level_changed;
    fade_mode_e        fade_mode;
  } result_t;

  typedef struct packed {
    logic [LevelW-1:0] cur;
    logic [LevelW-1:0] tgt;
    logic              fading_in;
    logic              fading_out;
    logic              last_moving;
    logic [LevelW-1:0] last_glow;
    logic [TicksW-1:0] poll_cnt;
    logic              fin_pend;
    logic [TicksW-1:0] fin_cnt;
    logic              fout_pend;
    logic [TicksW-1:0] fout_cnt;
    logic              off_armed;
    logic [OffW-1:0]   off_cnt;
  } state_t;

endpackage

>>> design/lfo_cfg_regs.sv
// Configuration register file: six fade / timing settings written by index.
// Depends on lfo_pkg.
`timescale 1ns / 1ps

module lfo_cfg_regs import lfo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_LEVEL:  cfg_d.min_level       = cfg_data_i[LevelW-1:0];
        CFG_MAX_LEVEL:  cfg_d.max_level       = cfg_data_i[LevelW-1:0];
        CFG_OFF_DELAY:  cfg_d.off_delay_ticks = cfg_data_i[OffW-1:0];
        CFG_POLL_TICKS: cfg_d.poll_ticks      = cfg_data_i[TicksW-1:0];
        CFG_STEP_SIZE:  cfg_d.step_size       = cfg_data_i[LevelW-1:0];
        CFG_STEP_TICKS: cfg_d.step_ticks      = cfg_data_i[TicksW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_level       <= MinLevelRst;
      cfg_q.max_level       <= MaxLevelRst;
      cfg_q.off_delay_ticks <= OffDelayRst;
      cfg_q.poll_ticks      <= PollTicksRst;
      cfg_q.step_size       <= StepSizeRst;
      cfg_q.step_ticks      <= StepTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> design/lfo_tick_core.sv
// Per-tick controller state and its single-pass update: auto-off job, poll job,
// fade-in step, fade-out step, in that order. Depends on lfo_pkg.
`timescale 1ns / 1ps

module lfo_tick_core import lfo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              step_i,
  input  logic              moving_i,
  input  logic [LevelW-1:0] glow_i,
  output result_t           res_o
);

  state_t            st_q, st_d;
  logic              off_due, fin_due, fout_due;
  logic [LevelW-1:0] step_amt;
  logic [LevelW:0]   up_sum;
  logic [LevelW-1:0] poll_tgt;
  logic [LevelW-1:0] glow_floor;

  function automatic logic [TicksW-1:0] dly10(input logic [TicksW-1:0] d);
    return (d == '0) ? '0 : d - 1'b1;
  endfunction

  function automatic state_t fade_in_start(input state_t s, input logic [LevelW-1:0] t);
    state_t r;
    r            = s;
    r.fading_in  = 1'b1;
    r.fading_out = 1'b0;
    r.cur        = '0;
    r.tgt        = t;
    r.fout_pend  = 1'b0;
    if (!r.fin_pend) begin
      r.fin_pend = 1'b1;
      r.fin_cnt  = '0;
    end
    return r;
  endfunction

  assign step_amt   = (cfg_i.step_size == '0) ? LevelW'(1) : cfg_i.step_size;
  assign glow_floor = (glow_i > cfg_i.min_level) ? glow_i : cfg_i.min_level;

  always_comb begin
    st_d     = st_q;
    off_due  = 1'b0;
    fin_due  = 1'b0;
    fout_due = 1'b0;
    up_sum   = '0;
    poll_tgt = '0;

    // auto-off job
    if (st_d.off_armed) begin
      if (st_d.off_cnt == '0) begin
        st_d.off_armed = 1'b0;
        off_due        = 1'b1;
      end else begin
        st_d.off_cnt = st_d.off_cnt - 1'b1;
      end
    end
    if (off_due && !moving_i) begin
      st_d.fading_in  = 1'b0;
      st_d.fading_out = 1'b1;
      if (!st_d.fout_pend) begin
        st_d.fout_pend = 1'b1;
        st_d.fout_cnt  = '0;
      end
    end

    // poll job
    if (st_d.poll_cnt == '0) begin
      st_d.poll_cnt = dly10(cfg_i.poll_ticks);
      if (st_d.fading_out || (moving_i && st_d.cur != '0)) begin
        st_d.last_moving = moving_i;
      end else begin
        if (moving_i) begin
          if (!st_d.last_moving) begin
            poll_tgt = (st_d.last_glow != '0) ? glow_floor : cfg_i.max_level;
            st_d     = fade_in_start(st_d, poll_tgt);
          end
          st_d.off_armed = 1'b0;
        end
        if (!moving_i && st_d.last_moving && st_d.cur != '0) begin
          st_d.off_armed = 1'b1;
          st_d.off_cnt   = (cfg_i.off_delay_ticks == '0) ? '0 : cfg_i.off_delay_ticks - 1'b1;
        end
        if (glow_i != st_d.last_glow) begin
          st_d.last_glow = glow_i;
          if (glow_i != '0) begin
            st_d           = fade_in_start(st_d, glow_floor);
            st_d.off_armed = 1'b1;
            st_d.off_cnt   = (cfg_i.off_delay_ticks == '0) ? '0 : cfg_i.off_delay_ticks - 1'b1;
          end
        end
        st_d.last_moving = moving_i;
      end
    end else begin
      st_d.poll_cnt = st_d.poll_cnt - 1'b1;
    end

    // fade-in step
    if (st_d.fin_pend) begin
      if (st_d.fin_cnt == '0) begin
        st_d.fin_pend = 1'b0;
        fin_due       = 1'b1;
      end else begin
        st_d.fin_cnt = st_d.fin_cnt - 1'b1;
      end
    end
    if (fin_due && st_d.fading_in && !st_d.fading_out) begin
      if (st_d.cur < st_d.tgt) begin
        up_sum        = {1'b0, st_d.cur} + {1'b0, step_amt};
        st_d.cur      = (up_sum < {1'b0, st_d.tgt}) ? up_sum[LevelW-1:0] : st_d.tgt;
        st_d.fin_pend = 1'b1;
        st_d.fin_cnt  = dly10(cfg_i.step_ticks);
      end else begin
        st_d.fading_in = 1'b0;
      end
    end

    // fade-out step
    if (st_d.fout_pend) begin
      if (st_d.fout_cnt == '0) begin
        st_d.fout_pend = 1'b0;
        fout_due       = 1'b1;
      end else begin
        st_d.fout_cnt = st_d.fout_cnt - 1'b1;
      end
    end
    if (fout_due && st_d.fading_out) begin
      if (st_d.cur != '0) begin
        st_d.cur       = (st_d.cur > step_amt) ? st_d.cur - step_amt : '0;
        st_d.fout_pend = 1'b1;
        st_d.fout_cnt  = dly10(cfg_i.step_ticks);
      end else begin
        st_d.fading_out = 1'b0;
      end
    end
  end

  always_comb begin
    res_o.level         = st_d.cur;
    res_o.level_changed = (st_d.cur != st_q.cur);
    if (st_d.fading_out) begin
      res_o.fade_mode = FADE_DOWN;
    end else if (st_d.fading_in) begin
      res_o.fade_mode = FADE_UP;
    end else begin
      res_o.fade_mode = FADE_STEADY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

>>> design/led_fade_auto_off_controller.sv
// LED fade controller with inactivity auto-off, one millisecond tick per
// request; each tick request yields exactly one result with the LED level,
// a changed flag and the fade mode. The block takes one request per clock
// cycle unless a held result blocks the input; a request passes through the
// input register, then the result register, and the throughput is set by the
// single-pass state update between those two registers. Configuration writes
// are always ready and take effect on the next cycle; no clearing pass runs
// after reset. Depends on lfo_pkg, lfo_cfg_regs and lfo_tick_core.
`timescale 1ns / 1ps

module led_fade_auto_off_controller import lfo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [InDatW-1:0]  s_axis_tdata_i,   // [0] moving, [7:1] glow_level
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [OutDatW-1:0] m_axis_tdata_o,   // [6:0] level, [7] level_changed,
                                               // [9:8] fade_mode, [15:10] zero
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i
);

  cfg_t              cfg;
  result_t           res;
  logic              in_valid_q, in_valid_d;
  logic              moving_q;
  logic [LevelW-1:0] glow_q;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;
  logic              advance;
  logic              s_fire;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  lfo_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lfo_tick_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (in_valid_q && advance),
    .moving_i (moving_q),
    .glow_i   (glow_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      moving_q <= s_axis_tdata_i[0];
      glow_q   <= s_axis_tdata_i[LevelW:1];
    end
    if (advance && in_valid_q) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDatW - LevelW - 3)'(0), out_q.fade_mode,
                            out_q.level_changed, out_q.level};

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a blocked result");

  a_take_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> in_valid_q)
    else $error("accepted request lost from input register");

  a_result_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_q && !out_valid_q) |=> !out_valid_q)
    else $error("result produced without a pending request");

  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (m_axis_tdata_o[9:8] != 2'b11 &&
                     m_axis_tdata_o[OutDatW-1:LevelW+3] == '0))
    else $error("bad fade mode or padding in result");

endmodule

>>> sim/led_fade_auto_off_controller_test.sv
// Self-checking testbench for led_fade_auto_off_controller: directed table, then random ticks.
// Carries its own tick-level predictor of the fade and auto-off behavior.
// Depends on lfo_pkg and the led_fade_auto_off_controller RTL.
`timescale 1ns / 1ps

module led_fade_auto_off_controller_test;
  import lfo_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned TickTarget = 1420;
  localparam int unsigned HoldOff    = 300;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    cfg_idx_e          idx;
    logic [CfgDatW-1:0] val;
    logic              mv;
    logic [LevelW-1:0] glow;
    logic              typed;
    result_t           res;
  } dir_row_t;

  localparam result_t NoRes = '0;
  localparam int DirRows = 29;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [InDatW-1:0]  s_axis_tdata_i;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [OutDatW-1:0] m_axis_tdata_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDatW-1:0] cfg_data_i;

  led_fade_auto_off_controller dut (.*);

  // predictor state
  cfg_t regs = '{MinLevelRst, MaxLevelRst, OffDelayRst, PollTicksRst,
                 StepSizeRst, StepTicksRst};
  logic [LevelW-1:0] lvl = '0;
  logic [LevelW-1:0] goal = '0;
  logic [LevelW-1:0] prev_glow = '0;
  logic              ramp_up = 1'b0;
  logic              ramp_down = 1'b0;
  logic              prev_moving = 1'b0;
  logic              up_pend = 1'b0;
  logic              down_pend = 1'b0;
  logic              off_pend = 1'b0;
  logic [15:0]       poll_cnt = '0;
  logic [15:0]       up_cnt = '0;
  logic [15:0]       down_cnt = '0;
  logic [15:0]       off_cnt = '0;

  result_t level_q [$];
  int unsigned ticks_sent = 0;
  int unsigned bad_results = 0;
  int unsigned pressure_reqs = 0;
  int unsigned idle_cycles = 0;

  dir_row_t dir_tab [DirRows] = '{
    '{ROW_CFG,  CFG_MIN_LEVEL,  16'd0,   1'b0, 7'd0,   1'b0, NoRes},
    '{ROW_CFG,  CFG_MAX_LEVEL,  16'd127, 1'b0, 7'd0,   1'b0, NoRes},
    '{ROW_CFG,  CFG_POLL_TICKS, 16'd0,   1'b0, 7'd0,   1'b0, NoRes},
    '{ROW_CFG,  CFG_STEP_TICKS, 16'd0,   1'b0, 7'd0,   1'b0, NoRes},
    '{ROW_CFG,  CFG_STEP_SIZE,  16'd127, 1'b0, 7'd0,   1'b0, NoRes},
    '{ROW_CFG,  CFG_OFF_DELAY,  16'd0,   1'b0, 7'd0,   1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b0, 7'd0,   1'b1, '{7'd0,   1'b0, FADE_STEADY}},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b1, 7'd0,   1'b1, '{7'd127, 1'b1, FADE_UP}},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b1, 7'd0,   1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b0, 7'd0,   1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b0, 7'd0,   1'b1, '{7'd0,   1'b1, FADE_DOWN}},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b0, 7'd0,   1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b0, 7'd100, 1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b0, 7'd100, 1'b0, NoRes},
    '{ROW_CFG,  CFG_STEP_SIZE,  16'd1,   1'b0, 7'd0,   1'b0, NoRes},
    '{ROW_CFG,  CFG_MIN_LEVEL,  16'd100, 1'b0, 7'd0,   1'b0, NoRes},
    '{ROW_CFG,  CFG_OFF_DELAY,  16'd3,   1'b0, 7'd0,   1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b1, 7'd0,   1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b1, 7'd0,   1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b0, 7'd0,   1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b1, 7'd0,   1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b1, 7'd5,   1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b0, 7'd5,   1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b0, 7'd127, 1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b0, 7'd127, 1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b0, 7'd127, 1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b0, 7'd127, 1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b1, 7'd127, 1'b0, NoRes},
    '{ROW_TICK, CFG_MIN_LEVEL,  16'd0,   1'b1, 7'd127, 1'b0, NoRes}
  };

  function automatic logic [15:0] less_one(input logic [15:0] d);
    return (d == 16'd0) ? 16'd0 : d - 16'd1;
  endfunction

  function automatic logic [LevelW-1:0] step_amt();
    return (regs.step_size == '0) ? 7'd1 : regs.step_size;
  endfunction

  function automatic logic [LevelW-1:0] glow_floor(input logic [LevelW-1:0] g);
    return (g > regs.min_level) ? g : regs.min_level;
  endfunction

  function automatic void arm_off();
    off_pend = 1'b1;
    off_cnt  = less_one(regs.off_delay_ticks);
  endfunction

  function automatic void restart_ramp(input logic [LevelW-1:0] target);
    ramp_up   = 1'b1;
    ramp_down = 1'b0;
    lvl       = '0;
    goal      = target;
    down_pend = 1'b0;
    if (!up_pend) begin
      up_pend = 1'b1;
      up_cnt  = '0;
    end
  endfunction

  // One millisecond tick: auto-off, poll, fade-in step, fade-out step.
  function automatic result_t led_tick(input logic mv, input logic [LevelW-1:0] glow);
    logic [LevelW-1:0] was;
    logic [LevelW:0]   nxt;
    result_t           r;
    was = lvl;

    if (off_pend) begin
      if (off_cnt == 16'd0) begin
        off_pend = 1'b0;
        if (!mv) begin
          ramp_up   = 1'b0;
          ramp_down = 1'b1;
          if (!down_pend) begin
            down_pend = 1'b1;
            down_cnt  = '0;
          end
        end
      end else begin
        off_cnt--;
      end
    end

    if (poll_cnt != 16'd0) begin
      poll_cnt--;
    end else begin
      poll_cnt = less_one(16'(regs.poll_ticks));
      if (ramp_down || (mv && lvl != '0)) begin
        prev_moving = mv;
      end else begin
        if (mv) begin
          if (!prev_moving) restart_ramp((prev_glow != '0) ? glow_floor(glow) : regs.max_level);
          off_pend = 1'b0;
        end
        if (!mv && prev_moving && lvl != '0) arm_off();
        if (glow != prev_glow) begin
          prev_glow = glow;
          if (glow != '0) begin
            restart_ramp(glow_floor(glow));
            arm_off();
          end
        end
        prev_moving = mv;
      end
    end

    if (up_pend) begin
      if (up_cnt == 16'd0) begin
        up_pend = 1'b0;
        if (ramp_up && !ramp_down) begin
          if (lvl < goal) begin
            nxt     = {1'b0, lvl} + {1'b0, step_amt()};
            lvl     = (nxt < {1'b0, goal}) ? nxt[LevelW-1:0] : goal;
            up_pend = 1'b1;
            up_cnt  = less_one(16'(regs.step_ticks));
          end else begin
            ramp_up = 1'b0;
          end
        end
      end else begin
        up_cnt--;
      end
    end

    if (down_pend) begin
      if (down_cnt == 16'd0) begin
        down_pend = 1'b0;
        if (ramp_down) begin
          if (lvl != '0) begin
            lvl       = (lvl > step_amt()) ? lvl - step_amt() : '0;
            down_pend = 1'b1;
            down_cnt  = less_one(16'(regs.step_ticks));
          end else begin
            ramp_down = 1'b0;
          end
        end
      end else begin
        down_cnt--;
      end
    end

    r.level         = lvl;
    r.level_changed = (lvl != was);
    r.fade_mode     = ramp_down ? FADE_DOWN : (ramp_up ? FADE_UP : FADE_STEADY);
    return r;
  endfunction

  task automatic send_tick(input logic mv, input logic [LevelW-1:0] glow,
                           input logic typed, input result_t fixed);
    result_t r;
    cfg_valid_i     <= 1'b0;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {glow, mv};
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = led_tick(mv, glow);
    level_q.push_back(typed ? fixed : r);
    ticks_sent++;
  endtask

  // only while idle: every pending result has come back
  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDatW-1:0] val);
    s_axis_tvalid_i <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MIN_LEVEL:  regs.min_level       = val[LevelW-1:0];
      CFG_MAX_LEVEL:  regs.max_level       = val[LevelW-1:0];
      CFG_OFF_DELAY:  regs.off_delay_ticks = val[OffW-1:0];
      CFG_POLL_TICKS: regs.poll_ticks      = val[TicksW-1:0];
      CFG_STEP_SIZE:  regs.step_size       = val[LevelW-1:0];
      CFG_STEP_TICKS: regs.step_ticks      = val[TicksW-1:0];
      default: ;
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random back-pressure plus the long hold-off on request
  initial begin
    int unsigned hold;
    int unsigned mode_left;
    int unsigned pick;
    int unsigned pressure_seen;
    logic        smooth;
    logic [LevelW-1:0] got_level;
    logic              got_changed;
    logic [1:0]        got_mode;
    result_t           want;
    hold = 0;
    mode_left = 0;
    pressure_seen = 0;
    smooth = 1'b0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_level   = m_axis_tdata_o[6:0];
        got_changed = m_axis_tdata_o[7];
        got_mode    = m_axis_tdata_o[9:8];
        if (level_q.size() == 0) begin
          $display("%0t: result without a pending tick: level %0d changed %0d mode %0d",
                   $time, got_level, got_changed, got_mode);
          bad_results++;
        end else begin
          want = level_q.pop_front();
          if (got_level !== want.level) begin
            $display("%0t: level expected %0d, got %0d", $time, want.level, got_level);
            bad_results++;
          end
          if (got_changed !== want.level_changed) begin
            $display("%0t: level_changed expected %0d, got %0d", $time,
                     want.level_changed, got_changed);
            bad_results++;
          end
          if (got_mode !== want.fade_mode) begin
            $display("%0t: fade_mode expected %0d, got %0d", $time, want.fade_mode, got_mode);
            bad_results++;
          end
        end
      end
      if (mode_left == 0) begin
        smooth    = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (pressure_seen != pressure_reqs) begin
        pressure_seen = pressure_reqs;
        hold = HoldOff;
      end else if (hold == 0 && !smooth) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) hold = 0;
        else if (pick < 96) hold = $urandom_range(1, 3);
        else hold = $urandom_range(10, 50);
      end
      if (hold > 0) begin
        m_axis_tready_i <= 1'b0;
        hold--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned n_items;
    int unsigned phase;
    int unsigned run_left;
    int unsigned gap;
    int unsigned pick;
    logic        last_phase;
    logic        tx_steady;
    logic        run_mv;
    logic [LevelW-1:0] glow_now;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_MIN_LEVEL;
    cfg_data_i      <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirRows; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        cfg_write(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_tick(dir_tab[i].mv, dir_tab[i].glow, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    phase = 0;
    run_left = 0;
    run_mv = 1'b0;
    glow_now = '0;
    last_phase = 1'b0;
    while (!last_phase) begin
      last_phase = (ticks_sent >= TickTarget);
      if (last_phase) begin
        // largest minimum level and timing settings, run last so the long poll countdown costs nothing
        cfg_write(CFG_MIN_LEVEL, 16'd127);
        cfg_write(CFG_MAX_LEVEL, 16'd100);
        cfg_write(CFG_OFF_DELAY, 16'd65535);
        cfg_write(CFG_POLL_TICKS, 16'd1023);
        cfg_write(CFG_STEP_SIZE, 16'd100);
        cfg_write(CFG_STEP_TICKS, 16'd1023);
        n_items = 50;
      end else begin
        cfg_write(CFG_MIN_LEVEL, 16'($urandom_range(0, 127)));
        cfg_write(CFG_MAX_LEVEL, 16'($urandom_range(0, 127)));
        cfg_write(CFG_OFF_DELAY, 16'(($urandom_range(0, 5) == 0) ? $urandom_range(41, 400)
                                                                 : $urandom_range(0, 40)));
        cfg_write(CFG_POLL_TICKS, 16'(($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
                                                                  : $urandom_range(0, 6)));
        cfg_write(CFG_STEP_SIZE, 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                                 : $urandom_range(1, 30)));
        cfg_write(CFG_STEP_TICKS, 16'(($urandom_range(0, 7) == 0) ? $urandom_range(6, 30)
                                                                  : $urandom_range(0, 5)));
        n_items = $urandom_range(60, 180);
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n_items; k++) begin
        if (phase == 1 && k == 20) pressure_reqs++;
        if (run_left == 0) begin
          run_mv   = ~run_mv;
          run_left = $urandom_range(1, 40);
        end
        run_left--;
        if ($urandom_range(0, 29) == 0) begin
          pick = $urandom_range(0, 7);
          if (pick < 2) glow_now = '0;
          else if (pick == 2) glow_now = LevelW'($urandom_range(100, 127));
          else glow_now = LevelW'($urandom_range(1, 100));
        end
        if ($urandom_range(0, 9) == 0) begin
          send_tick(1'($urandom_range(0, 1)), LevelW'($urandom_range(0, 127)), 1'b0, NoRes);
        end else begin
          send_tick(run_mv, glow_now, 1'b0, NoRes);
        end
        if (!tx_steady) begin
          pick = $urandom_range(0, 99);
          if (pick < 70) gap = 0;
          else if (pick < 95) gap = $urandom_range(1, 3);
          else gap = $urandom_range(10, 40);
          if (gap != 0) begin
            s_axis_tvalid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
      end
      phase++;
    end

    s_axis_tvalid_i <= 1'b0;
    cfg_valid_i     <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (bad_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
